// ----- src/pce_pkg.sv -----
// Package for the parametric CRC engine: shared types, register index codes,
// reset values and the helper functions that derive the working settings.
// No dependencies.
`default_nettype none

package pce_pkg;

   localparam int MaxWidth      = 32;
   localparam int MinWidth      = 4;
   localparam int CsrIndexWidth = 3;

   typedef logic [MaxWidth-1:0] crc_type;
   typedef logic [5:0]          width_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_WIDTH   = 3'd0,
      CSR_POLY    = 3'd1,
      CSR_INIT    = 3'd2,
      CSR_XOR     = 3'd3,
      CSR_REFIN   = 3'd4,
      CSR_REFOUT  = 3'd5
   } csr_index_type;

   typedef struct packed {
      width_type   crc_width;
      logic [31:0] polynomial;
      logic [31:0] init_value;
      logic [31:0] xor_out;
      logic        reflect_in;
      logic        reflect_out;
   } raw_cfg_type;

   // Settings as the datapath uses them, derived once per register write.
   typedef struct packed {
      width_type width;
      crc_type   mask;
      crc_type   topbit;
      crc_type   wpoly;
      crc_type   preset;
      crc_type   xor_out;
      logic      reflect_in;
      logic      flip;
   } cfg_type;

   typedef struct packed {
      logic    reload;
      crc_type reload_value;
   } reload_type;

   localparam raw_cfg_type RawCfgReset = '{
      crc_width:   6'd32,
      polynomial:  32'h04C11DB7,
      init_value:  32'hFFFFFFFF,
      xor_out:     32'hFFFFFFFF,
      reflect_in:  1'b1,
      reflect_out: 1'b1
   };

   function automatic crc_type width_mask(input width_type w);
      crc_type m;
      if (w >= width_type'(MaxWidth)) begin
         m = '1;
      end else begin
         m = (crc_type'(1) << w) - crc_type'(1);
      end
      return m;
   endfunction

   function automatic crc_type reflect_bits(input crc_type v, input width_type w);
      crc_type rev;
      for (int i = 0; i < MaxWidth; i++) begin
         rev[MaxWidth-1-i] = v[i];
      end
      return rev >> (width_type'(MaxWidth) - w);
   endfunction

   function automatic cfg_type derive_cfg(input raw_cfg_type raw);
      cfg_type   c;
      width_type w;
      crc_type   m;
      crc_type   p;
      crc_type   v;
      if (raw.crc_width < width_type'(MinWidth)) begin
         w = width_type'(MinWidth);
      end else if (raw.crc_width > width_type'(MaxWidth)) begin
         w = width_type'(MaxWidth);
      end else begin
         w = raw.crc_width;
      end
      m = width_mask(w);
      p = crc_type'(raw.polynomial) & m;
      v = crc_type'(raw.init_value) & m;
      c.width      = w;
      c.mask       = m;
      c.topbit     = crc_type'(1) << (w - width_type'(1));
      c.wpoly      = raw.reflect_in ? reflect_bits(p, w) : p;
      c.preset     = raw.reflect_in ? reflect_bits(v, w) : v;
      c.xor_out    = crc_type'(raw.xor_out) & m;
      c.reflect_in = raw.reflect_in;
      c.flip       = raw.reflect_in ^ raw.reflect_out;
      return c;
   endfunction

   localparam cfg_type CfgReset = derive_cfg(RawCfgReset);

endpackage

`default_nettype wire

// ----- src/pce_csr.sv -----
// Configuration registers of the CRC engine and the derived working settings.
// Depends on pce_pkg.
`default_nettype none

module pce_csr import pce_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [31:0]              csr_wdata,
   output cfg_type                       cfg,
   output reload_type                    reload
);

   raw_cfg_type raw_ff, raw_in;
   cfg_type     cfg_ff, cfg_in;
   logic        hit;

   assign csr_ready = 1'b1;

   always_comb begin
      raw_in = raw_ff;
      hit    = 1'b0;
      if (csr_valid) begin
         hit = 1'b1;
         case (csr_index)
            CSR_WIDTH:  raw_in.crc_width   = csr_wdata[5:0];
            CSR_POLY:   raw_in.polynomial  = csr_wdata;
            CSR_INIT:   raw_in.init_value  = csr_wdata;
            CSR_XOR:    raw_in.xor_out     = csr_wdata;
            CSR_REFIN:  raw_in.reflect_in  = csr_wdata[0];
            CSR_REFOUT: raw_in.reflect_out = csr_wdata[0];
            default:    hit = 1'b0;
         endcase
      end
      cfg_in = derive_cfg(raw_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= RawCfgReset;
         cfg_ff <= CfgReset;
      end else if (hit) begin
         raw_ff <= raw_in;
         cfg_ff <= cfg_in;
      end
   end

   assign cfg                 = cfg_ff;
   assign reload.reload       = hit;
   assign reload.reload_value = cfg_in.preset;

endmodule

`default_nettype wire

// ----- src/pce_update.sv -----
// Byte update of the running CRC and the finishing step for the last byte.
// Depends on pce_pkg.
`default_nettype none

module pce_update import pce_pkg::*; (
   input  wire cfg_type     cfg,
   input  wire crc_type     crc_cur,
   input  wire logic [7:0]  data_byte,
   output crc_type          crc_next,
   output logic [31:0]      crc_result
);

   crc_type c;
   crc_type fin;
   logic    b;

   always_comb begin
      c = crc_cur & cfg.mask;
      for (int i = 0; i < 8; i++) begin
         if (cfg.reflect_in) begin
            b = c[0] ^ data_byte[i];
            c = c >> 1;
         end else begin
            b = (|(c & cfg.topbit)) ^ data_byte[7-i];
            c = (c << 1) & cfg.mask;
         end
         if (b) begin
            c = c ^ cfg.wpoly;
         end
      end
      crc_next   = c & cfg.mask;
      fin        = cfg.flip ? reflect_bits(crc_next, cfg.width) : crc_next;
      fin        = (fin ^ cfg.xor_out) & cfg.mask;
      crc_result = fin[31:0];
   end

endmodule

`default_nettype wire

// ----- src/parametric_crc_engine.sv -----
// Top level of the parametric CRC engine: running CRC register, result register
// and handshakes. Depends on pce_pkg, pce_csr and pce_update.
//
// One byte is taken per request, one per clock cycle sustained; the full 8-bit
// update is one XOR network between the CRC register and itself, so a byte
// can follow in the very next cycle. A request with last_byte set yields one
// result in the result register in the next cycle, and the CRC register is
// preset again for the next message. Requests stall only while a finished
// result waits and the result side is not ready. Configuration writes are
// taken every cycle; any write to a defined register presets the CRC register
// and so drops a message in progress.
`default_nettype none

module parametric_crc_engine import pce_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic                     req_last_byte,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [31:0]                   rsp_crc_result,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [31:0]              csr_wdata
);

   cfg_type     cfg;
   reload_type  reload;
   crc_type     crc_ff, crc_in;
   crc_type     crc_next;
   logic [31:0] result;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        accept;

   pce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .reload    (reload)
   );

   pce_update u_update (
      .cfg        (cfg),
      .crc_cur    (crc_ff),
      .data_byte  (req_data_byte),
      .crc_next   (crc_next),
      .crc_result (result)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         crc_in = req_last_byte ? cfg.preset : crc_next;
         if (req_last_byte) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end
      end
      if (reload.reload) begin
         crc_in = reload.reload_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CfgReset.preset;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crc_result = rsp_data_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=> rsp_valid_ff)
      else $error("last byte accepted without a result");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while result is blocked");

   a_preset_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte && !reload.reload) |=> (crc_ff == $past(cfg.preset)))
      else $error("CRC register not preset after last byte");

   a_crc_in_width: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_last_byte && !reload.reload) |=> ((crc_ff & ~$past(cfg.mask)) == '0))
      else $error("CRC register has bits above the width");

endmodule

`default_nettype wire
